@@ rtl/core/dart_pkg.sv @@
// dart_pkg: shared types, address map and rate table for the divider and reload timer
// used by the controller, datapath, top level and checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dart_pkg;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [15:0] ADDR_DIV  = 16'hFF04;
   localparam logic [15:0] ADDR_TIMA = 16'hFF05;
   localparam logic [15:0] ADDR_TMA  = 16'hFF06;
   localparam logic [15:0] ADDR_TAC  = 16'hFF07;

   localparam int TAC_ENABLE_BIT = 2;

   // timer prescaler working width: up to 1023 held plus 255 new cycles
   localparam int PRESCALE_W = 11;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  cycles;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_request;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_COUNT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic more;
      logic out_free;
   } status_type;

   function automatic logic [PRESCALE_W-1:0] rate_period(input logic [1:0] rate);
      logic [PRESCALE_W-1:0] period;
      case (rate)
         2'd0: period = 11'd1024;
         2'd1: period = 11'd16;
         2'd2: period = 11'd64;
         2'd3: period = 11'd256;
         default: period = 11'd1024;
      endcase
      return period;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/divider_and_reload_timer_top.sv @@
// Divider and reload timer, top level.
// Depends on dart_pkg, dart_ctrl and dart_datapath.
//
// Channels: a request channel (req_valid, req_ready, req_data) carries one
// item: a tick of some clock cycles, a register read or a register write.
// A response channel (rsp_valid, rsp_ready, rsp_data) returns exactly one
// result per request: the read byte (0xFF for an unmapped address) and the
// interrupt request raised when the timer counter wrapped during a tick.
// The sequencer steps the timer counter one increment per cycle before it
// hands the result over; after a switch to a faster rate the held prescaler
// can catch up by as many as 79 increments on the next tick.
// A new request is taken once the previous one has left the sequencer; the
// result register lets one result wait for the receiver meanwhile.
// When the receiver stalls with a result already waiting, the sequencer
// holds the next finished result and takes no further request.
// Reset clears the divider, counter, modulo and control registers and both
// prescalers; the timer comes out disabled at rate setting 0, its slowest rate.
`timescale 1ns / 1ps
`default_nettype none

module divider_and_reload_timer_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dart_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dart_pkg::rsp_type      rsp_data
);

   dart_pkg::cmd_type    cmd;
   dart_pkg::status_type status;

   dart_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dart_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/core/dart_ctrl.sv @@
// dart_ctrl: request sequencer for the divider and reload timer
// depends on dart_pkg; drives datapath commands from its status
`timescale 1ns / 1ps
`default_nettype none

module dart_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire dart_pkg::status_type status,
   output dart_pkg::cmd_type       cmd
);

   dart_pkg::state_type state_ff;
   dart_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dart_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dart_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = dart_pkg::ST_COUNT;
            end
         end
         dart_pkg::ST_COUNT: begin
            if (!status.more && status.out_free) begin
               state_in = dart_pkg::ST_IDLE;
            end
         end
         default: state_in = dart_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         dart_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         dart_pkg::ST_COUNT: begin
            // one counter increment per cycle, then hand the result over
            cmd.step = status.more;
            cmd.emit = !status.more && status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/dart_datapath.sv @@
// dart_datapath: divider, timer counter, registers and result register
// depends on dart_pkg; commanded by dart_ctrl
`timescale 1ns / 1ps
`default_nettype none

module dart_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dart_pkg::cmd_type  cmd,
   output dart_pkg::status_type    status,
   input  wire dart_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output dart_pkg::rsp_type       rsp_data
);

   logic [7:0]                      div_count_ff, div_count_in;
   logic [7:0]                      div_prescale_ff, div_prescale_in;
   logic [7:0]                      timer_count_ff, timer_count_in;
   logic [dart_pkg::PRESCALE_W-1:0] timer_prescale_ff, timer_prescale_in;
   logic [7:0]                      reload_ff, reload_in;
   logic [7:0]                      control_ff, control_in;
   logic                            tick_ff, tick_in;
   logic [7:0]                      rd_ff, rd_in;
   logic                            irq_ff, irq_in;
   dart_pkg::rsp_type               rsp_ff, rsp_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic [8:0]                      div_sum;
   logic [dart_pkg::PRESCALE_W-1:0] period;
   logic                            timer_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_count_ff      <= '0;
         div_prescale_ff   <= '0;
         timer_count_ff    <= '0;
         timer_prescale_ff <= '0;
         reload_ff         <= '0;
         control_ff        <= '0;
         tick_ff           <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         div_count_ff      <= div_count_in;
         div_prescale_ff   <= div_prescale_in;
         timer_count_ff    <= timer_count_in;
         timer_prescale_ff <= timer_prescale_in;
         reload_ff         <= reload_in;
         control_ff        <= control_in;
         tick_ff           <= tick_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff  <= rd_in;
      irq_ff <= irq_in;
      rsp_ff <= rsp_in;
   end

   assign div_sum  = {1'b0, div_prescale_ff} + {1'b0, req_data.cycles};
   assign period   = dart_pkg::rate_period(control_ff[1:0]);
   assign timer_en = control_ff[dart_pkg::TAC_ENABLE_BIT];

   assign status.more     = tick_ff && (timer_prescale_ff >= period);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      div_count_in      = div_count_ff;
      div_prescale_in   = div_prescale_ff;
      timer_count_in    = timer_count_ff;
      timer_prescale_in = timer_prescale_ff;
      reload_in         = reload_ff;
      control_in        = control_ff;
      tick_in           = tick_ff;
      rd_in             = rd_ff;
      irq_in            = irq_ff;
      rsp_in            = rsp_ff;
      rsp_valid_in      = rsp_valid_ff;

      if (cmd.load) begin
         tick_in = 1'b0;
         irq_in  = 1'b0;
         rd_in   = 8'h00;
         case (req_data.op)
            dart_pkg::OP_TICK: begin
               div_prescale_in = div_sum[7:0];
               div_count_in    = div_count_ff + {7'b0, div_sum[8]};
               if (timer_en) begin
                  timer_prescale_in = timer_prescale_ff
                                    + dart_pkg::PRESCALE_W'(req_data.cycles);
                  tick_in = 1'b1;
               end
            end
            dart_pkg::OP_READ: begin
               case (req_data.address)
                  dart_pkg::ADDR_DIV:  rd_in = div_count_ff;
                  dart_pkg::ADDR_TIMA: rd_in = timer_count_ff;
                  dart_pkg::ADDR_TMA:  rd_in = reload_ff;
                  dart_pkg::ADDR_TAC:  rd_in = control_ff;
                  default:             rd_in = 8'hFF;
               endcase
            end
            dart_pkg::OP_WRITE: begin
               case (req_data.address)
                  dart_pkg::ADDR_DIV: begin
                     div_count_in      = '0;
                     div_prescale_in   = '0;
                     timer_prescale_in = '0;
                  end
                  dart_pkg::ADDR_TIMA: timer_count_in = req_data.write_data;
                  dart_pkg::ADDR_TMA:  reload_in      = req_data.write_data;
                  dart_pkg::ADDR_TAC:  control_in     = req_data.write_data;
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end

      if (cmd.step) begin
         timer_prescale_in = timer_prescale_ff - period;
         if (timer_count_ff == 8'hFF) begin
            timer_count_in = reload_ff;
            irq_in         = 1'b1;
         end else begin
            timer_count_in = timer_count_ff + 8'd1;
         end
      end

      if (cmd.emit) begin
         rsp_in.read_data   = rd_ff;
         rsp_in.irq_request = irq_ff;
         rsp_valid_in       = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/core/dart_checker.sv @@
// dart_checker: port-level checks for the divider and reload timer
// depends on dart_pkg; bound to divider_and_reload_timer_top
`timescale 1ns / 1ps
`default_nettype none

module dart_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire dart_pkg::rsp_type rsp_data
);

   // no response is pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a request is never taken in back-to-back cycles
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one in progress");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_data))
      else $error("response changed while stalled");

endmodule

bind divider_and_reload_timer_top dart_checker u_checker (.*);

`default_nettype wire
